// File: hdl/vvt_pkg.sv
// ----------------------------------------------------------------------------
// vvt_pkg: shared types and constants for the four-voice voicing transform
// Voicing mode codes, note constants, melodic offsets and the voice bundle.
// ----------------------------------------------------------------------------
package vvt_pkg;

  localparam int unsigned NoteW   = 7;
  localparam int unsigned Voices  = 4;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned PdataW  = 32;
  localparam int unsigned PaddrW  = 2;

  localparam logic [NoteW-1:0] Octave = 7'd12;

  typedef enum logic [ModeW-1:0] {
    MODE_CLOSED   = 3'd0,
    MODE_DROP2    = 3'd1,
    MODE_DROP3    = 3'd2,
    MODE_DROP24   = 3'd3,
    MODE_UNISON   = 3'd4,
    MODE_OCTAVES  = 3'd5,
    MODE_DOUBLING = 3'd6
  } voicing_mode_e;

  // index 0 is the top voice
  typedef struct packed {
    logic [Voices-1:0][NoteW-1:0] note;
    logic [Voices-1:0]            on;
  } voice_set_t;

  typedef struct packed {
    voice_set_t       chord;
    logic signed [7:0] melody;
    logic             slash;
  } chord_item_t;

  // melodic offset for a voice, 9-bit signed
  function automatic logic signed [8:0] melodic_offset(voicing_mode_e  mode,
                                                      logic [1:0]     voice);
    logic signed [8:0] off;
    off = 9'sd0;
    case (mode)
      MODE_OCTAVES: begin
        case (voice)
          2'd1, 2'd2: off = -9'sd12;
          2'd3:       off = -9'sd24;
          default:    off = 9'sd0;
        endcase
      end
      MODE_DOUBLING: begin
        case (voice)
          2'd2, 2'd3: off = -9'sd12;
          default:    off = 9'sd0;
        endcase
      end
      default: off = 9'sd0;
    endcase
    return off;
  endfunction

endpackage

// File: hdl/four_voice_voicing_transform.sv
// ----------------------------------------------------------------------------
// four_voice_voicing_transform: closed, drop and melodic four-voice voicings
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------------
//   in       | in_valid_i / in_ready_o  | melody, voice1..4 notes/on, slash
//   out      | out_valid_o / out_ready_i| out1..4 notes/on
//   config   | APB psel/penable/pready  | voicing_mode at byte address 0
//
// One transfer per cycle unless the output stalls; path: input register,
// transform, result register. No clearing pass after reset; the mode resets
// to closed. A stalled output holds its result while the input register still
// takes one more item; ready falls only when both registers are full.
// ----------------------------------------------------------------------------
module four_voice_voicing_transform
  import vvt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic signed [7:0] melody_note_i,
  input  logic [NoteW-1:0]  voice1_note_i,
  input  logic [NoteW-1:0]  voice2_note_i,
  input  logic [NoteW-1:0]  voice3_note_i,
  input  logic [NoteW-1:0]  voice4_note_i,
  input  logic              voice1_on_i,
  input  logic              voice2_on_i,
  input  logic              voice3_on_i,
  input  logic              voice4_on_i,
  input  logic              slash_bass_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NoteW-1:0]  out1_note_o,
  output logic [NoteW-1:0]  out2_note_o,
  output logic [NoteW-1:0]  out3_note_o,
  output logic [NoteW-1:0]  out4_note_o,
  output logic              out1_on_o,
  output logic              out2_on_o,
  output logic              out3_on_o,
  output logic              out4_on_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  voicing_mode_e mode;
  chord_item_t   in_item;
  chord_item_t   s1_item_q, s1_item_d;
  logic          s1_valid_q, s1_valid_d;
  voice_set_t    xf_voices;
  voice_set_t    out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic          s1_adv;
  logic          in_xfer;

  vvt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  assign in_item.chord.note = {voice4_note_i, voice3_note_i, voice2_note_i, voice1_note_i};
  assign in_item.chord.on   = {voice4_on_i, voice3_on_i, voice2_on_i, voice1_on_i};
  assign in_item.melody     = melody_note_i;
  assign in_item.slash      = slash_bass_i;

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign in_xfer    = in_valid_i & in_ready_o;

  vvt_xform u_xform (
    .item_i   (s1_item_q),
    .mode_i   (mode),
    .voices_o (xf_voices)
  );

  always_comb begin
    s1_item_d   = s1_item_q;
    s1_valid_d  = s1_valid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      out_d       = xf_voices;
      out_valid_d = 1'b1;
      s1_valid_d  = 1'b0;
    end
    if (in_xfer) begin
      s1_item_d  = in_item;
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= s1_item_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out1_note_o = out_q.note[0];
  assign out2_note_o = out_q.note[1];
  assign out3_note_o = out_q.note[2];
  assign out4_note_o = out_q.note[3];
  assign out1_on_o   = out_q.on[0];
  assign out2_on_o   = out_q.on[1];
  assign out3_on_o   = out_q.on[2];
  assign out4_on_o   = out_q.on[3];

`ifndef SYNTHESIS
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_valid_q)
    else $error("accepted item not held in input register");

  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced item missing from result register");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_item_q))
    else $error("blocked input register lost its item");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("ready low with free space");
`endif

endmodule

// File: hdl/vvt_cfg_regs.sv
// ----------------------------------------------------------------------------
// vvt_cfg_regs: APB configuration register
// Holds the voicing mode; write on the access phase, read back on prdata.
// ----------------------------------------------------------------------------
module vvt_cfg_regs
  import vvt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output voicing_mode_e     mode_o
);

  voicing_mode_e mode_q, mode_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = voicing_mode_e'(pwdata[ModeW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CLOSED;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == '0) begin
      prdata[ModeW-1:0] = mode_q;
    end
  end

  assign mode_o = mode_q;

endmodule

// File: hdl/vvt_xform.sv
// ----------------------------------------------------------------------------
// vvt_xform: voicing transform datapath
// Closed, drop and melodic voicings of one chord item, purely combinational.
// ----------------------------------------------------------------------------
module vvt_xform
  import vvt_pkg::*;
(
  input  chord_item_t   item_i,
  input  voicing_mode_e mode_i,
  output voice_set_t    voices_o
);

  always_comb begin
    logic [NoteW-1:0]  lo2, lo3, lo4;
    logic              ok2, ok3, ok4;
    logic [NoteW-1:0]  a, b, c, t;
    logic              drop_ok;
    logic              complete;
    logic signed [8:0] n;

    lo2      = item_i.chord.note[1] - Octave;
    lo3      = item_i.chord.note[2] - Octave;
    lo4      = item_i.chord.note[3] - Octave;
    ok2      = item_i.chord.note[1] >= Octave;
    ok3      = item_i.chord.note[2] >= Octave;
    ok4      = item_i.chord.note[3] >= Octave;
    complete = &item_i.chord.on;
    a        = '0;
    b        = '0;
    c        = '0;
    t        = '0;
    n        = '0;
    drop_ok  = 1'b0;
    voices_o = item_i.chord;

    case (mode_i)
      MODE_DROP2: begin
        a       = item_i.chord.note[2];
        b       = item_i.chord.note[3];
        c       = lo2;
        drop_ok = complete & ~item_i.slash & ok2;
      end
      MODE_DROP3: begin
        a       = item_i.chord.note[1];
        b       = item_i.chord.note[3];
        c       = lo3;
        drop_ok = complete & ~item_i.slash & ok3;
      end
      MODE_DROP24: begin
        a       = lo2;
        b       = item_i.chord.note[2];
        c       = lo4;
        drop_ok = complete & ok2 & ok4;
      end
      default: drop_ok = 1'b0;
    endcase

    // three-way descending sort
    if (b > a) begin
      t = a; a = b; b = t;
    end
    if (c > a) begin
      t = a; a = c; c = t;
    end
    if (c > b) begin
      t = b; b = c; c = t;
    end

    if (drop_ok) begin
      voices_o.note[1] = a;
      voices_o.note[2] = b;
      voices_o.note[3] = c;
      voices_o.on      = '1;
    end

    if (mode_i == MODE_UNISON || mode_i == MODE_OCTAVES || mode_i == MODE_DOUBLING) begin
      for (int i = 0; i < Voices; i++) begin
        n = {item_i.melody[7], item_i.melody} + melodic_offset(mode_i, 2'(i));
        voices_o.on[i]   = ~item_i.melody[7] & ~n[8];
        voices_o.note[i] = voices_o.on[i] ? n[NoteW-1:0] : '0;
      end
    end
  end

endmodule

// File: verif/tb_four_voice_voicing_transform.sv
// ----------------------------------------------------------------------------
// tb_four_voice_voicing_transform: self-checking bench for the voicing block
// Walks every voicing mode with a few fixed chords, then runs random phases
// of mostly well-formed closed chords with random handshake gaps on both
// channels. Each accepted chord is predicted in the bench and each result
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_four_voice_voicing_transform;
  import vvt_pkg::*;

  localparam logic [ModeW-1:0]  ModeSpare  = 3'd7;
  localparam logic [PaddrW-1:0] ModeAddr   = '0;
  localparam int unsigned       PhaseLen   = 75;
  localparam int unsigned       Phases     = 10;
  localparam int unsigned       LongHold   = 48;
  localparam int unsigned       QuietLimit = 4000;

  typedef struct packed {
    logic [Voices-1:0][NoteW-1:0] note;
    logic [Voices-1:0]            on;
  } voices_t;

  typedef struct packed {
    logic signed [7:0] melody;
    voices_t           closed;
    logic              slash;
  } chord_t;

  class voicing_checker;
    logic [ModeW-1:0] mode;
    voices_t          expected_voicings[$];
    int unsigned      fails;

    function new();
      mode  = MODE_CLOSED;
      fails = 0;
    endfunction

    function void set_mode(logic [ModeW-1:0] m);
      mode = m;
    endfunction

    function int melodic_shift(int v);
      case (mode)
        MODE_OCTAVES:  return (v == 0) ? 0 : (v == 3) ? -24 : -12;
        MODE_DOUBLING: return (v >= 2) ? -12 : 0;
        default:       return 0;
      endcase
    endfunction

    function void note_chord(chord_t c);
      voices_t r;
      int      v[Voices];
      int      low[3];
      int      n, t, i, j;
      bit      ok;
      r = c.closed;
      for (i = 0; i < Voices; i++) v[i] = int'(c.closed.note[i]);
      case (mode)
        MODE_UNISON, MODE_OCTAVES, MODE_DOUBLING: begin
          for (i = 0; i < Voices; i++) begin
            n = int'(c.melody) + melodic_shift(i);
            if (c.melody >= 0 && n >= 0 && n <= 127) begin
              r.note[i] = n[NoteW-1:0];
              r.on[i]   = 1'b1;
            end else begin
              r.note[i] = '0;
              r.on[i]   = 1'b0;
            end
          end
        end
        MODE_DROP2, MODE_DROP3, MODE_DROP24: begin
          if (&c.closed.on) begin
            if (mode == MODE_DROP2) begin
              low = '{v[2], v[3], v[1] - 12};
              ok  = !c.slash && low[2] >= 0;
            end else if (mode == MODE_DROP3) begin
              low = '{v[1], v[3], v[2] - 12};
              ok  = !c.slash && low[2] >= 0;
            end else begin
              low = '{v[1] - 12, v[2], v[3] - 12};
              ok  = low[0] >= 0 && low[2] >= 0;
            end
            if (ok) begin
              for (i = 0; i < 3; i++)
                for (j = i + 1; j < 3; j++)
                  if (low[j] > low[i]) begin
                    t      = low[i];
                    low[i] = low[j];
                    low[j] = t;
                  end
              for (i = 0; i < 3; i++) begin
                r.note[i+1] = low[i][NoteW-1:0];
                r.on[i+1]   = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      expected_voicings.push_back(r);
    endfunction

    function void check_voices(voices_t got);
      voices_t want;
      int      i;
      if (expected_voicings.size() == 0) begin
        $error("voicing result with no chord outstanding");
        fails++;
        return;
      end
      want = expected_voicings.pop_front();
      for (i = 0; i < Voices; i++) begin
        if (got.note[i] !== want.note[i]) begin
          $error("out%0d_note: expected %0d, got %0d", i + 1, want.note[i], got.note[i]);
          fails++;
        end
        if (got.on[i] !== want.on[i]) begin
          $error("out%0d_on: expected %0d, got %0d", i + 1, want.on[i], got.on[i]);
          fails++;
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic signed [7:0] melody_note_i;
  logic [NoteW-1:0]  voice1_note_i, voice2_note_i, voice3_note_i, voice4_note_i;
  logic              voice1_on_i, voice2_on_i, voice3_on_i, voice4_on_i;
  logic              slash_bass_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [NoteW-1:0]  out1_note_o, out2_note_o, out3_note_o, out4_note_o;
  logic              out1_on_o, out2_on_o, out3_on_o, out4_on_o;
  logic              psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  voicing_checker   sb;
  bit               src_busy;
  bit               snk_busy;
  bit               hold_output;
  int unsigned      quiet_cycles;
  chord_t           directed[3];
  logic [ModeW-1:0] mode_walk[8] = '{MODE_CLOSED, MODE_DROP2, MODE_DROP3, MODE_DROP24,
                                     MODE_UNISON, MODE_OCTAVES, MODE_DOUBLING, ModeSpare};

  four_voice_voicing_transform dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_chord('{melody_note_i,
                      '{{voice4_note_i, voice3_note_i, voice2_note_i, voice1_note_i},
                        {voice4_on_i, voice3_on_i, voice2_on_i, voice1_on_i}},
                      slash_bass_i});
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_voices('{{out4_note_o, out3_note_o, out2_note_o, out1_note_o},
                        {out4_on_o, out3_on_o, out2_on_o, out1_on_o}});
  end

  // watchdog: cycles without any transfer or register access
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("** four_voice_voicing_transform: FAILED **");
        $finish;
      end
    end
  end

  // result side
  initial begin : sink
    int gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = snk_busy ? $urandom_range(0, 6) : 0;
      if (hold_output) begin
        gap         = LongHold;
        hold_output = 1'b0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic send_chord(chord_t c);
    int gap;
    gap = src_busy ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    melody_note_i <= c.melody;
    voice1_note_i <= c.closed.note[0];
    voice2_note_i <= c.closed.note[1];
    voice3_note_i <= c.closed.note[2];
    voice4_note_i <= c.closed.note[3];
    voice1_on_i   <= c.closed.on[0];
    voice2_on_i   <= c.closed.on[1];
    voice3_on_i   <= c.closed.on[2];
    voice4_on_i   <= c.closed.on[3];
    slash_bass_i  <= c.slash;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_voicings.size() != 0);
  endtask

  task automatic write_mode(logic [ModeW-1:0] m);
    wait_drained();
    repeat (3) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ModeAddr;
    pwdata  <= PdataW'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_mode(m);
  endtask

  // mostly descending closed chords, the rest arbitrary
  function automatic chord_t make_chord();
    chord_t c;
    int     pitch, k;
    if ($urandom_range(0, 3) == 0) begin
      c.melody        = 8'($urandom_range(0, 255));
      c.closed.note   = 28'($urandom);
      c.closed.on     = 4'($urandom_range(0, 15));
      c.slash         = 1'($urandom_range(0, 1));
    end else begin
      pitch = $urandom_range(0, 127);
      c.closed.note[0] = 7'(pitch);
      for (k = 1; k < Voices; k++) begin
        pitch = pitch - $urandom_range(1, 5);
        if (pitch < 0) pitch = 0;
        c.closed.note[k] = 7'(pitch);
      end
      c.closed.on = '1;
      c.slash     = ($urandom_range(0, 4) == 0);
      c.melody    = ($urandom_range(0, 9) == 0) ? -8'sd1 : 8'($urandom_range(0, 127));
    end
    return c;
  endfunction

  initial begin : stimulus
    logic [ModeW-1:0] m;
    int               ph, k;
    sb            = new();
    quiet_cycles  = 0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    melody_note_i <= '0;
    voice1_note_i <= '0;
    voice2_note_i <= '0;
    voice3_note_i <= '0;
    voice4_note_i <= '0;
    voice1_on_i   <= 1'b0;
    voice2_on_i   <= 1'b0;
    voice3_on_i   <= 1'b0;
    voice4_on_i   <= 1'b0;
    slash_bass_i  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;

    directed[0] = '{8'sd127, '{{7'd60, 7'd64, 7'd67, 7'd72}, 4'b1111}, 1'b0};
    // lowered notes go negative, slash bass, lowest melody
    directed[1] = '{-8'sd128, '{{7'd0, 7'd5, 7'd11, 7'd127}, 4'b1111}, 1'b1};
    // incomplete chord, melody at the bottom of the range
    directed[2] = '{8'sd0, '{{7'd0, 7'd127, 7'd127, 7'd127}, 4'b1101}, 1'b0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_busy = 1'b1;
    snk_busy = 1'b1;
    foreach (mode_walk[i]) begin
      write_mode(mode_walk[i]);
      foreach (directed[j]) send_chord(directed[j]);
    end

    for (ph = 0; ph < Phases; ph++) begin
      m        = (ph < 8) ? mode_walk[ph] : mode_walk[$urandom_range(0, 7)];
      src_busy = (ph != 3) && ($urandom_range(0, 2) != 0);
      snk_busy = ($urandom_range(0, 2) != 0);
      write_mode(m);
      // back-pressure: sink stalls long while the source keeps offering
      if (ph == 3) hold_output = 1'b1;
      for (k = 0; k < PhaseLen; k++) begin
        if (ph == 5 && k == PhaseLen / 2) wait_drained();
        send_chord(make_chord());
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.fails == 0)
      $display("** four_voice_voicing_transform: PASSED **");
    else
      $display("** four_voice_voicing_transform: FAILED **");
    $finish;
  end

endmodule
